### design/mps_pkg.sv
// Shared types, constants and helper functions for the Mandelbrot pixel shader.
// Used by mps_ctrl, mps_datapath and mandelbrot_pixel_shade_core; depends on nothing.
package mps_pkg;

  localparam int FRAC_BITS = 28;
  localparam int INT_BITS  = 4;
  localparam int FX_W      = INT_BITS + FRAC_BITS;
  localparam int PROD_W    = 2 * FX_W - FRAC_BITS;
  localparam int SUM_W     = PROD_W + 4;

  localparam int PIX_W     = 12;
  localparam int DIM_W     = 13;
  localparam int ITER_W    = 10;
  localparam int NORM_W    = 3;
  localparam int SHADE_W   = 8;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_W     = PIX_W + 3;
  localparam int DEN_W     = DIM_W + 1;
  localparam int SPROD_W   = ITER_W + SHADE_W;

  localparam int RATIO_STEPS = FX_W;
  localparam int SHADE_STEPS = SHADE_W;
  localparam int CNT_W       = $clog2(RATIO_STEPS);

  localparam logic [DIM_W-1:0]  WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = DIM_W'(1080);
  localparam logic [ITER_W-1:0] ITER_RESET   = ITER_W'(50);
  localparam logic [NORM_W-1:0] NORM_RESET   = NORM_W'(2);

  localparam logic signed [SUM_W-1:0] SAT_HI    = (SUM_W'(1) << (FX_W - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_LO    = -(SUM_W'(1) << (FX_W - 1));
  localparam logic signed [SUM_W-1:0] OFFSET_RE = SUM_W'(5) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] OFFSET_IM = SUM_W'(1) << FRAC_BITS;

  typedef logic signed [FX_W-1:0] fx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 2'd0,
    REG_IMAGE_HEIGHT   = 2'd1,
    REG_MAX_ITERATIONS = 2'd2,
    REG_ESCAPE_NORM    = 2'd3
  } mps_reg_t;

  typedef enum logic [1:0] {
    DIV_RE,
    DIV_IM,
    DIV_SHADE
  } div_src_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iteration_count;
    logic [SHADE_W-1:0] shade;
  } pixel_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]  image_width;
    logic [DIM_W-1:0]  image_height;
    logic [ITER_W-1:0] max_iterations;
    logic [NORM_W-1:0] escape_norm;
  } mps_cfg_t;

  typedef struct packed {
    logic     pix_load;
    logic     div_load;
    div_src_t div_src;
    logic     div_step;
    logic     cre_store;
    logic     cim_store;
    logic     iter_clear;
    logic     mul_en;
    logic     step_en;
    logic     out_load;
  } mps_cmd_t;

  typedef struct packed {
    logic done;
  } mps_stat_t;

  function automatic fx_t fx_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[FX_W-1:0];
  endfunction

  function automatic logic [FX_W-1:0] fx_mag(input fx_t a);
    logic [FX_W-1:0] m;
    m = a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
    return m;
  endfunction

endpackage

### design/mps_ctrl.sv
// Controller state machine for the Mandelbrot pixel shader.
// Sequences the datapath through mapping, iteration and shading; uses mps_pkg.
module mps_ctrl
  import mps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pix_valid,
  output logic      pix_ready,
  output logic      res_valid,
  input  logic      res_ready,
  input  mps_stat_t stat,
  output mps_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_RE_LOAD   = 11'b000_0000_0010,
    S_RE_DIV    = 11'b000_0000_0100,
    S_IM_LOAD   = 11'b000_0000_1000,
    S_IM_DIV    = 11'b000_0001_0000,
    S_ITER_INIT = 11'b000_0010_0000,
    S_MUL       = 11'b000_0100_0000,
    S_STEP      = 11'b000_1000_0000,
    S_SH_LOAD   = 11'b001_0000_0000,
    S_SH_DIV    = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             res_valid_next;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.div_src    = DIV_RE;
    pix_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        pix_ready = 1'b1;
        if (pix_valid) begin
          cmd.pix_load = 1'b1;
          state_next   = S_RE_LOAD;
        end
      end
      S_RE_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_RE;
        cnt_next     = CNT_W'(RATIO_STEPS - 1);
        state_next   = S_RE_DIV;
      end
      S_RE_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_IM_LOAD;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_IM_LOAD: begin
        cmd.cre_store = 1'b1;
        cmd.div_load  = 1'b1;
        cmd.div_src   = DIV_IM;
        cnt_next      = CNT_W'(RATIO_STEPS - 1);
        state_next    = S_IM_DIV;
      end
      S_IM_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_ITER_INIT;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_ITER_INIT: begin
        cmd.cim_store  = 1'b1;
        cmd.iter_clear = 1'b1;
        state_next     = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (stat.done) begin
          state_next = S_SH_LOAD;
        end else begin
          cmd.step_en = 1'b1;
          state_next  = S_MUL;
        end
      end
      S_SH_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DIV_SHADE;
        cnt_next     = CNT_W'(SHADE_STEPS - 1);
        state_next   = S_SH_DIV;
      end
      S_SH_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (cmd.out_load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

### design/mps_datapath.sv
// Datapath of the Mandelbrot pixel shader: shared radix-2 divider, point
// registers, three multipliers, update and escape test, result register. Uses mps_pkg.
module mps_datapath
  import mps_pkg::*;
(
  input  logic       clk,
  input  pixel_in_t  pix,
  input  mps_cfg_t   cfg,
  input  mps_cmd_t   cmd,
  output mps_stat_t  stat,
  output pixel_out_t res
);

  pixel_in_t          pix_q;
  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   rem;
  logic [FX_W-1:0]    dvd;
  logic [FX_W-1:0]    quo;
  logic               ovf;
  fx_t                cre, cim, re, im;
  logic [ITER_W-1:0]  n;
  logic [PROD_W-1:0]  rr, ii, ri;
  logic               ri_neg;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [NUM_W-1:0]   num_sel;
  logic [DEN_W-1:0]   den_sel;
  logic [SPROD_W-1:0] sprod;
  logic [DEN_W:0]     rem_sh;
  logic               qbit;
  logic [FX_W:0]      ratio;
  logic signed [SUM_W-1:0] map_val;
  logic signed [SUM_W-1:0] map_off;
  logic [PROD_W:0]    norm;
  logic [PROD_W:0]    bound;
  logic [FX_W-1:0]    mag_re, mag_im;
  logic [2*FX_W-1:0]  p_rr, p_ii, p_ri;
  logic signed [SUM_W-1:0] ri_s, re_sum, im_sum;

  assign w_eff = (cfg.image_width == '0) ? DIM_W'(1) : cfg.image_width;
  assign h_eff = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
  assign sprod = {n, SHADE_W'(0)} - SPROD_W'(n);

  always_comb begin
    num_sel = '0;
    den_sel = '0;
    unique case (cmd.div_src)
      DIV_RE: begin
        num_sel = NUM_W'(pix_q.pixel_x) * NUM_W'(7);
        den_sel = {w_eff, 1'b0};
      end
      DIV_IM: begin
        num_sel = NUM_W'({pix_q.pixel_y, 1'b0});
        den_sel = DEN_W'(h_eff);
      end
      DIV_SHADE: begin
        num_sel = '0;
        den_sel = DEN_W'(cfg.max_iterations);
      end
      default: begin
        num_sel = '0;
        den_sel = '0;
      end
    endcase
  end

  assign rem_sh = {rem, dvd[FX_W-1]};
  assign qbit   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      den <= den_sel;
      quo <= '0;
      if (cmd.div_src == DIV_SHADE) begin
        rem <= DEN_W'(sprod[SPROD_W-1:SHADE_W]);
        dvd <= {sprod[SHADE_W-1:0], (FX_W - SHADE_W)'(0)};
        ovf <= 1'b0;
      end else begin
        rem <= DEN_W'(num_sel[NUM_W-1:INT_BITS]);
        dvd <= {num_sel[INT_BITS-1:0], FRAC_BITS'(0)};
        ovf <= ((DEN_W + INT_BITS)'(num_sel) >= {den_sel, INT_BITS'(0)});
      end
    end else if (cmd.div_step) begin
      rem <= qbit ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
      dvd <= {dvd[FX_W-2:0], 1'b0};
      quo <= {quo[FX_W-2:0], qbit};
    end
  end

  assign ratio   = ovf ? {1'b1, FX_W'(0)} : {1'b0, quo};
  assign map_off = cmd.cre_store ? OFFSET_RE : OFFSET_IM;
  assign map_val = $signed({(SUM_W - FX_W - 1)'(0), ratio}) - map_off;

  assign mag_re = fx_mag(re);
  assign mag_im = fx_mag(im);
  assign p_rr   = (2*FX_W)'(mag_re) * (2*FX_W)'(mag_re);
  assign p_ii   = (2*FX_W)'(mag_im) * (2*FX_W)'(mag_im);
  assign p_ri   = (2*FX_W)'(mag_re) * (2*FX_W)'(mag_im);

  assign norm  = {1'b0, rr} + {1'b0, ii};
  assign bound = (PROD_W + 1)'(cfg.escape_norm) << FRAC_BITS;
  assign stat.done = (norm >= bound) || (n >= cfg.max_iterations);

  assign ri_s   = ri_neg ? -$signed({(SUM_W - PROD_W)'(0), ri})
                         : $signed({(SUM_W - PROD_W)'(0), ri});
  assign re_sum = $signed({(SUM_W - PROD_W)'(0), rr}) - $signed({(SUM_W - PROD_W)'(0), ii})
                + $signed({{(SUM_W - FX_W){cre[FX_W-1]}}, cre});
  assign im_sum = (ri_s <<< 1) + $signed({{(SUM_W - FX_W){cim[FX_W-1]}}, cim});

  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      pix_q <= pix;
    end
    if (cmd.cre_store) begin
      cre <= fx_sat(map_val);
    end
    if (cmd.cim_store) begin
      cim <= fx_sat(map_val);
    end
    if (cmd.iter_clear) begin
      re <= '0;
      im <= '0;
      n  <= '0;
    end else if (cmd.step_en) begin
      re <= fx_sat(re_sum);
      im <= fx_sat(im_sum);
      n  <= n + ITER_W'(1);
    end
    if (cmd.mul_en) begin
      rr     <= p_rr[2*FX_W-1:FRAC_BITS];
      ii     <= p_ii[2*FX_W-1:FRAC_BITS];
      ri     <= p_ri[2*FX_W-1:FRAC_BITS];
      ri_neg <= re[FX_W-1] ^ im[FX_W-1];
    end
    if (cmd.out_load) begin
      res.iteration_count <= n;
      res.shade <= (cfg.max_iterations == '0) ? SHADE_W'(0) : quo[SHADE_W-1:0];
    end
  end

endmodule

### design/mandelbrot_pixel_shade_core.sv
// Top level of the Mandelbrot escape-time pixel shader: configuration registers,
// controller and datapath. Uses mps_pkg, mps_ctrl and mps_datapath.
//
//   Channel   Signals                          Contents
//   pixel     pix_valid, pix_ready, pix        pixel_x, pixel_y
//   result    res_valid, res_ready, res        iteration_count, shade
//   config    cfg_write, cfg_index, cfg_data   one register write per cycle
//
// The time from a pixel's transaction to its result is set by the shared radix-2 divider
// (32 steps per axis, 8 for the shade) and by the iteration loop of a multiply state
// and an update state.
// A result waits in the output register while the next pixel is taken and processed.
// Reset is synchronous and returns the registers to 1920, 1080, 50 and 2.
module mandelbrot_pixel_shade_core
  import mps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  pixel_in_t            pix,
  output logic                 res_valid,
  input  logic                 res_ready,
  output pixel_out_t           res,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  mps_cfg_t  cfg;
  mps_cmd_t  cmd;
  mps_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= WIDTH_RESET;
      cfg.image_height   <= HEIGHT_RESET;
      cfg.max_iterations <= ITER_RESET;
      cfg.escape_norm    <= NORM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data;
        REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data;
        REG_MAX_ITERATIONS: cfg.max_iterations <= cfg_data[ITER_W-1:0];
        REG_ESCAPE_NORM:    cfg.escape_norm    <= cfg_data[NORM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mps_datapath u_datapath (
    .clk  (clk),
    .pix  (pix),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat),
    .res  (res)
  );

endmodule
